[rtl/core/mpm_pkg.sv]
`default_nettype none

package mpm_pkg;

    // Width of the candidate field on the input channel.
    localparam int CAND_W = 63;

    // Default width of the value that is actually examined.
    localparam int VALUE_WIDTH_DEF = 63;

    // Width of the persistence count and of the running maximum.
    localparam int PERS_W = 4;

    // Number base of the digits.
    localparam int RADIX = 10;

    // The round count saturates at this value.
    localparam logic [PERS_W-1:0] PERS_CAP = 4'd15;

endpackage

`default_nettype wire

[rtl/core/mpm_in_if.sv]
`default_nettype none

interface mpm_in_if
    import mpm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CAND_W-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink (input valid, input candidate, output ready);
endinterface

`default_nettype wire

[rtl/core/mpm_out_if.sv]
`default_nettype none

interface mpm_out_if
    import mpm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PERS_W-1:0] persistence;
    logic              new_record;
    logic [PERS_W-1:0] best_so_far;

    modport source (output valid, output persistence, output new_record,
                    output best_so_far, input ready);
    modport sink (input valid, input persistence, input new_record,
                  input best_so_far, output ready);
endinterface

`default_nettype wire

[rtl/core/multiplicative_persistence_max_core.sv]
// Multiplicative persistence with a running maximum.
// The req channel carries one candidate number per beat; only its low
// VALUE_WIDTH bits are examined. The rsp channel returns one beat per
// candidate: the persistence, a flag that is set when it beats the running
// maximum, and the maximum after this candidate.
// One candidate is worked on at a time. After the accepting edge the value
// is checked; each digit-product round then converts it to decimal and
// multiplies its digits (up to 19) into the running product, until the value
// has a single digit. The block is ready for the next candidate only after
// the result has moved to the output register, so it never takes a new
// candidate before it is through with the last one. The binary-to-decimal
// conversion handles four bits a cycle and a single small multiplier takes
// one digit a cycle.
// A finished result sits in the rsp output register; the next candidate is
// taken meanwhile, and its result waits until the receiver has taken the
// previous beat. A stalled receiver thus stops the input once a second
// result is waiting.
// Reset clears the running maximum to zero and empties the output register.
`default_nettype none

module multiplicative_persistence_max_core
    import mpm_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    mpm_in_if.sink     req,
    mpm_out_if.source  rsp
);

    // Binary word padded to whole nibbles, and the decimal digit count.
    localparam int STEPS  = (VALUE_WIDTH + 3) / 4;
    localparam int BIN_W  = STEPS * 4;
    localparam int DIGITS = (VALUE_WIDTH * 1233) / 4096 + 2;
    localparam int BCD_W  = DIGITS * 4;
    localparam int CNT_W  = $clog2(STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CONV,
        ST_MUL,
        ST_FIN
    } state_t;

    state_t                 state_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [VALUE_WIDTH-1:0] prod_reg;
    logic [BIN_W-1:0]       bin_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [PERS_W-1:0]      rounds_reg;
    logic [PERS_W-1:0]      max_reg;
    logic                   out_valid_reg;
    logic [PERS_W-1:0]      out_pers_reg;
    logic                   out_rec_reg;
    logic [PERS_W-1:0]      out_best_reg;

    logic [BIN_W-1:0]       bin_next;
    logic [BCD_W-1:0]       bcd_next;
    logic [BCD_W-1:0]       bcd_shr;
    logic [VALUE_WIDTH-1:0] prod_next;
    logic                   record;
    logic                   fin_load;

    // Four double-dabble steps: correct each digit, then shift one bit in.
    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        for (int k = 0; k < 4; k++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (bcd_next[4*d +: 4] >= 4'd5)
                begin
                    bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
                end
            end
            bcd_next = {bcd_next[BCD_W-2:0], bin_next[BIN_W-1]};
            bin_next = {bin_next[BIN_W-2:0], 1'b0};
        end
    end

    // Shared digit multiplier: running product times the lowest digit.
    assign prod_next = prod_reg * VALUE_WIDTH'(bcd_reg[3:0]);
    assign bcd_shr   = bcd_reg >> 4;

    assign record = rounds_reg > max_reg;

    // The finished result moves into the output register when it is free.
    assign fin_load = (state_reg == ST_FIN) && (!out_valid_reg || rsp.ready);

    // Handshake and payload outputs.
    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.persistence = out_pers_reg;
    assign rsp.new_record  = out_rec_reg;
    assign rsp.best_so_far = out_best_reg;

    // Sequencer, datapath registers and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            val_reg       <= '0;
            prod_reg      <= '0;
            bin_reg       <= '0;
            bcd_reg       <= '0;
            cnt_reg       <= '0;
            rounds_reg    <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_pers_reg  <= '0;
            out_rec_reg   <= 1'b0;
            out_best_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && !fin_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        val_reg    <= req.candidate[VALUE_WIDTH-1:0];
                        rounds_reg <= '0;
                        state_reg  <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (val_reg < VALUE_WIDTH'(RADIX))
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        bin_reg   <= BIN_W'(val_reg);
                        bcd_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    bin_reg <= bin_next;
                    bcd_reg <= bcd_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(STEPS - 1))
                    begin
                        prod_reg  <= VALUE_WIDTH'(1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg <= prod_next;
                    bcd_reg  <= bcd_shr;
                    // The round ends when no digits remain or the product is zero.
                    if (bcd_shr == '0 || prod_next == '0)
                    begin
                        val_reg <= prod_next;
                        if (rounds_reg != PERS_CAP)
                        begin
                            rounds_reg <= rounds_reg + 1'b1;
                        end
                        state_reg <= ST_CHECK;
                    end
                end
                ST_FIN:
                begin
                    if (fin_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pers_reg  <= rounds_reg;
                        out_rec_reg   <= record;
                        out_best_reg  <= record ? rounds_reg : max_reg;
                        if (record)
                        begin
                            max_reg <= rounds_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[sim/mpm_persistence_checker.sv]
`timescale 1ns / 1ps

module mpm_persistence_checker
    import mpm_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire  clk,
    input  wire  rst_n,
    mpm_in_if    req,
    mpm_out_if   rsp,
    output int   mismatches,
    output int   leftover
);

    typedef struct packed {
        logic [PERS_W-1:0] persistence;
        logic              new_record;
        logic [PERS_W-1:0] best_so_far;
    } persist_score_t;

    localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_WIDTH) - 64'd1;
    localparam logic [63:0] BASE = 64'(RADIX);

    persist_score_t    expected_scores [$];
    logic [PERS_W-1:0] best_rounds;

    // Count digit-product rounds until one digit is left, saturating at the cap.
    function automatic logic [PERS_W-1:0] count_digit_rounds(input logic [63:0] value);
        logic [63:0]       current;
        logic [63:0]       product;
        logic [63:0]       rest;
        logic [PERS_W-1:0] rounds;
        current = value;
        rounds = '0;
        while (current >= BASE)
        begin
            product = 64'd1;
            rest = current;
            do
            begin
                product = product * (rest % BASE);
                rest = rest / BASE;
            end
            while (rest != 64'd0 && product != 64'd0);
            current = product;
            if (rounds < PERS_CAP)
                rounds = rounds + 1'b1;
        end
        return rounds;
    endfunction

    // Predict on every accepted candidate and check every accepted result beat.
    always @(posedge clk or negedge rst_n)
    begin
        persist_score_t predicted;
        persist_score_t oldest;
        if (!rst_n)
        begin
            expected_scores.delete();
            best_rounds = '0;
            mismatches = 0;
            leftover <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predicted.persistence = count_digit_rounds(64'(req.candidate) & VALUE_MASK);
                predicted.new_record = predicted.persistence > best_rounds;
                if (predicted.new_record)
                    best_rounds = predicted.persistence;
                predicted.best_so_far = best_rounds;
                expected_scores = {expected_scores, predicted};
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_scores.size() == 0)
                begin
                    $error("result beat arrived with no candidate outstanding");
                    mismatches++;
                end
                else
                begin
                    oldest = expected_scores.pop_front();
                    if (rsp.persistence !== oldest.persistence)
                    begin
                        $error("persistence: expected %0d, actual %0d",
                               oldest.persistence, rsp.persistence);
                        mismatches++;
                    end
                    if (rsp.new_record !== oldest.new_record)
                    begin
                        $error("new_record: expected %0b, actual %0b",
                               oldest.new_record, rsp.new_record);
                        mismatches++;
                    end
                    if (rsp.best_so_far !== oldest.best_so_far)
                    begin
                        $error("best_so_far: expected %0d, actual %0d",
                               oldest.best_so_far, rsp.best_so_far);
                        mismatches++;
                    end
                end
            end
            leftover <= expected_scores.size();
        end
    end

endmodule

[sim/multiplicative_persistence_max_core_test.sv]
`timescale 1ns / 1ps

module multiplicative_persistence_max_core_test
    import mpm_pkg::*;
();

    localparam int DIRECTED_COUNT = 22;
    localparam int RANDOM_COUNT = 1700;
    localparam int ITEM_COUNT = DIRECTED_COUNT + RANDOM_COUNT;
    localparam int CALM_TAIL = 200;
    localparam int HOLD_OFF_AT = 150;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int QUIET_LIMIT = 8000;
    localparam int SETTLE_CYCLES = 450;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   results_taken = 0;
    int   quiet_cycles = 0;
    int   mismatches;
    int   leftover;

    mpm_in_if  req_bus ();
    mpm_out_if rsp_bus ();

    multiplicative_persistence_max_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    mpm_persistence_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_bus),
        .rsp        (rsp_bus),
        .mismatches (mismatches),
        .leftover   (leftover)
    );

    // Clock and a single reset at the start.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result beats taken so far; updated late so other processes see a stable count.
    always @(posedge clk)
    begin
        if (rsp_bus.valid && rsp_bus.ready)
            results_taken <= results_taken + 1;
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Idling is allowed outside every third stretch of 128 beats and the calm tail.
    function automatic bit idling_allowed(input int index);
        return (index < ITEM_COUNT - CALM_TAIL) && ((index / 128) % 3 != 2);
    endfunction

    // Reorder the decimal digits of a value; the digit product stays the same.
    function automatic logic [63:0] shuffle_digits(input logic [63:0] value);
        int unsigned digits [20];
        int          count;
        int          pick;
        int unsigned held;
        logic [63:0] rebuilt;
        count = 0;
        while (value != 64'd0)
        begin
            digits[count] = int'(value % 64'd10);
            value = value / 64'd10;
            count++;
        end
        for (int i = count - 1; i > 0; i--)
        begin
            pick = $urandom_range(i, 0);
            held = digits[i];
            digits[i] = digits[pick];
            digits[pick] = held;
        end
        rebuilt = 64'd0;
        for (int i = 0; i < count; i++)
            rebuilt = rebuilt * 64'd10 + 64'(digits[i]);
        return rebuilt;
    endfunction

    // A run of mostly nonzero digits, so the products stay large for several rounds.
    function automatic logic [63:0] random_digit_run();
        int          len;
        int          digit;
        logic [63:0] acc;
        len = $urandom_range(19, 2);
        acc = 64'd0;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9, 0) == 0)
                digit = $urandom_range(9, 0);
            else
                digit = $urandom_range(9, 2);
            // A 19-digit value must stay below 2**63.
            if (len == 19 && i == 0)
                digit = $urandom_range(8, 1);
            acc = acc * 64'd10 + 64'(digit);
        end
        return acc;
    endfunction

    // Random candidate mix: raw bit patterns, small values, deep digit sets, and random digit runs.
    function automatic logic [CAND_W-1:0] random_candidate();
        logic [63:0] deep_seeds [4];
        int          roll;
        deep_seeds = '{64'd2677889, 64'd26888999, 64'd3778888999, 64'd277777788888899};
        roll = $urandom_range(99, 0);
        if (roll < 30)
            return CAND_W'({$urandom, $urandom});
        else if (roll < 40)
            return CAND_W'($urandom_range(999, 0));
        else if (roll < 60)
            return CAND_W'(shuffle_digits(deep_seeds[$urandom_range(3, 0)]));
        else
            return CAND_W'(random_digit_run());
    endfunction

    // Sender: corner values first, then random candidates, then the verdict.
    initial
    begin
        logic [CAND_W-1:0] corner_values [DIRECTED_COUNT];
        logic [CAND_W-1:0] value;
        corner_values = '{
            63'd0, 63'd9, 63'd10, 63'd11, 63'd25, 63'd39, 63'd77, 63'd679,
            63'd6788, 63'd68889, 63'd2677889, 63'd26888999, 63'd3778888999,
            63'd277777788888899, 63'd998888887777772, 63'd100,
            63'd1000000000000000000, 63'd1111111111111111111,
            63'd8888888888888888888, 63'd999999999999999999,
            63'd9223372036854775807, 63'h2AAA_AAAA_AAAA_AAAA
        };
        req_bus.valid = 1'b0;
        req_bus.candidate = '0;
        wait (rst_n);
        @(posedge clk);
        for (int n = 0; n < ITEM_COUNT; n++)
        begin
            value = (n < DIRECTED_COUNT) ? corner_values[n] : random_candidate();
            req_bus.valid <= 1'b1;
            req_bus.candidate <= value;
            @(posedge clk);
            while (!req_bus.ready)
                @(posedge clk);
            if (idling_allowed(n) && $urandom_range(3, 0) == 0)
            begin
                req_bus.valid <= 1'b0;
                req_bus.candidate <= CAND_W'({$urandom, $urandom});
                repeat ($urandom_range(4, 1)) @(posedge clk);
            end
        end
        req_bus.valid <= 1'b0;

        // Drain, then let the block sit for about one worst-case candidate.
        while (results_taken != ITEM_COUNT)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && leftover == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold-off that backs up the input.
    initial
    begin
        bit held_off;
        held_off = 1'b0;
        rsp_bus.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        rsp_bus.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!held_off && results_taken >= HOLD_OFF_AT)
            begin
                held_off = 1'b1;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                rsp_bus.ready <= 1'b1;
            end
            else if (idling_allowed(results_taken) && $urandom_range(5, 0) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(4, 1)) @(posedge clk);
                rsp_bus.ready <= 1'b1;
            end
        end
    end

endmodule
